### src/stc_pkg.sv
// Shared constants, transaction types and segment-unit structs for the scatter transaction counter.
package stc_pkg;

    localparam int unsigned MAX_BUCKETS = 256;
    localparam int unsigned BKT_W       = $clog2(MAX_BUCKETS);
    localparam int unsigned NB_W        = BKT_W + 1;
    localparam int unsigned WARP_WIDTH  = 32;
    localparam int unsigned WARP_BITS   = $clog2(WARP_WIDTH);
    localparam int unsigned MAX_VALUES  = 65536;
    localparam int unsigned CNT_W       = 17;
    localparam int unsigned KEY_W       = 8;
    localparam int unsigned TOT_W       = 32;
    localparam int unsigned SEG_WORDS   = 32;
    localparam int unsigned SEG_BITS    = $clog2(SEG_WORDS);
    localparam int unsigned SEG_HI_W    = TOT_W - SEG_BITS;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned REG_SEL_BIT = 2;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_KEY    = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_VALUE_COUNT  = 1'b1;

    localparam logic [NB_W-1:0]  BUCKET_COUNT_RST = NB_W'(2);

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] bucket;
        logic [CNT_W-1:0] gather_offset;
        logic [CNT_W-1:0] scatter_offset;
        logic [KEY_W-1:0] key;
    } req_data_t;

    typedef struct packed {
        logic [TOT_W-1:0] opt_transactions;
        logic [TOT_W-1:0] simple_transactions;
    } rsp_data_t;

    // One segment count request: start = diff + base, span n words
    typedef struct packed {
        logic             valid;
        logic             to_opt;
        logic [TOT_W-1:0] diff;
        logic [TOT_W-1:0] base;
        logic [TOT_W-1:0] n;
    } seg_req_t;

    typedef struct packed {
        logic             valid;
        logic             to_opt;
        logic [TOT_W-1:0] count;
    } seg_rsp_t;

endpackage

### src/stc_seg.sv
// Pipelined segment counter: aligned segments spanned by n words from a start word.
module stc_seg
    import stc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  seg_req_t req,
    output seg_rsp_t rsp,
    output logic     busy
);

    logic                a_valid_reg;
    logic                a_opt_reg;
    logic [TOT_W-1:0]    a_diff_reg;
    logic [TOT_W-1:0]    a_base_reg;
    logic [TOT_W-1:0]    a_n_reg;
    logic                b_valid_reg;
    logic                b_opt_reg;
    logic [TOT_W-1:0]    b_start_reg;
    logic [TOT_W-1:0]    b_n_reg;
    logic                c_valid_reg;
    logic                c_opt_reg;
    logic                c_nz_reg;
    logic [SEG_HI_W-1:0] c_hi_reg;
    logic [SEG_HI_W-1:0] c_lo_reg;
    logic                d_valid_reg;
    logic                d_opt_reg;
    logic [TOT_W-1:0]    d_count_reg;
    logic [TOT_W-1:0]    c_end_next;

    assign c_end_next = b_start_reg + b_n_reg + TOT_W'(SEG_WORDS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= req.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_opt_reg    <= req.to_opt;
        a_diff_reg   <= req.diff;
        a_base_reg   <= req.base;
        a_n_reg      <= req.n;

        b_opt_reg    <= a_opt_reg;
        b_start_reg  <= a_diff_reg + a_base_reg;
        b_n_reg      <= a_n_reg;

        c_opt_reg    <= b_opt_reg;
        c_nz_reg     <= (b_n_reg != '0);
        c_hi_reg     <= c_end_next[TOT_W-1:SEG_BITS];
        c_lo_reg     <= b_start_reg[TOT_W-1:SEG_BITS];

        d_opt_reg    <= c_opt_reg;
        // an empty span touches no segment
        d_count_reg  <= c_nz_reg ? {{SEG_BITS{1'b0}}, c_hi_reg - c_lo_reg} : '0;
    end

    assign rsp.valid  = d_valid_reg;
    assign rsp.to_opt = d_opt_reg;
    assign rsp.count  = d_count_reg;
    assign busy       = a_valid_reg | b_valid_reg | c_valid_reg | d_valid_reg;

endmodule

### src/scatter_transaction_counter.sv
// Top level of the scatter transaction counter: tables, key run tracking, bucket walk, totals.
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_stall     req_data   (req_data_t)
//   rsp       out         rsp_valid / rsp_stall     rsp_data   (rsp_data_t)
//   config    in          psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// A load transaction, and a key transaction that extends the current run, completes in the
// idle state; a key transaction that opens a run also passes through ST_KEY_RD for the table read.
// A finish transaction reads the table entry of each of the nb buckets in use, one table read a
// cycle over the walk, then the four-stage segment pipeline drains before the result.
// Reset clears the counters and control state; the tables are not cleared.
// A result waits in the output register while rsp_stall is high; a further finish holds
// in the drain state until the output register is free.
module scatter_transaction_counter
    import stc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_data_t          req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_data_t          rsp_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_KEY_RD   = 5'b00010,
        ST_WALK     = 5'b00100,
        ST_WALK_END = 5'b01000,
        ST_DRAIN    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] gather_mem  [MAX_BUCKETS];
    logic [CNT_W-1:0] scatter_mem [MAX_BUCKETS];
    logic [CNT_W-1:0] gather_q;
    logic [CNT_W-1:0] scatter_q;
    logic             rd_en;
    logic [BKT_W-1:0] rd_addr;
    logic             load_we;

    logic [NB_W-1:0]  bucket_count_reg;
    logic [CNT_W-1:0] value_count_reg;
    logic             cfg_we;

    logic [CNT_W-1:0] elem_idx_reg;
    logic [CNT_W-1:0] run_start_reg;
    logic [KEY_W-1:0] run_key_reg;
    logic [TOT_W-1:0] diff_reg;
    logic             last_reg;
    logic [NB_W-1:0]  rd_cnt_reg;
    logic [CNT_W-1:0] prev_gather_reg;
    logic [CNT_W-1:0] prev_scatter_reg;
    logic [TOT_W-1:0] simple_total_reg;
    logic [TOT_W-1:0] opt_total_reg;
    logic             rsp_valid_reg;
    rsp_data_t        rsp_data_reg;

    logic             accept;
    logic             key_go;
    logic             fin_go;
    logic             new_run;
    logic [WARP_BITS-1:0] pos;
    logic [NB_W-1:0]  nb;
    logic [CNT_W-1:0] nv;
    logic [CNT_W-1:0] warp_limit;
    logic [TOT_W-1:0] diff_next;
    logic             rsp_free;
    logic             rsp_load;

    seg_req_t         seg_req;
    seg_rsp_t         seg_rsp;
    logic             seg_busy;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_BUCKET_COUNT: prdata = PDATA_W'(bucket_count_reg);
            REG_VALUE_COUNT:  prdata = PDATA_W'(value_count_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
            value_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[REG_SEL_BIT])
                REG_BUCKET_COUNT: bucket_count_reg <= pwdata[NB_W-1:0];
                REG_VALUE_COUNT:  value_count_reg  <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---- derived limits ----
    assign nb = (bucket_count_reg > NB_W'(MAX_BUCKETS)) ? NB_W'(MAX_BUCKETS) : bucket_count_reg;
    assign nv = (value_count_reg > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES) : value_count_reg;
    assign warp_limit = nv & ~CNT_W'(WARP_WIDTH - 1);

    // ---- tables ----
    assign load_we = accept && (req_data.req_type == REQ_LOAD);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            gather_mem[req_data.bucket] <= req_data.gather_offset;
        end
        if (rd_en)
        begin
            gather_q <= gather_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            scatter_mem[req_data.bucket] <= req_data.scatter_offset;
        end
        if (rd_en)
        begin
            scatter_q <= scatter_mem[rd_addr];
        end
    end

    // ---- control ----
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign key_go    = accept && (req_data.req_type == REQ_KEY) && (elem_idx_reg < warp_limit);
    assign fin_go    = accept && (req_data.req_type == REQ_FINISH);
    assign pos       = elem_idx_reg[WARP_BITS-1:0];
    assign new_run   = (pos == '0) || (req_data.key != run_key_reg);
    assign diff_next = TOT_W'(scatter_q) - TOT_W'(gather_q);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        seg_req    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        rsp_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_go)
                begin
                    if (new_run)
                    begin
                        // fetch the new run's table entries
                        rd_en      = 1'b1;
                        rd_addr    = req_data.key;
                        state_next = ST_KEY_RD;
                    end
                    if (new_run && (pos != '0))
                    begin
                        // close the run that this key ends
                        seg_req.valid = 1'b1;
                        seg_req.diff  = diff_reg;
                        seg_req.base  = TOT_W'(run_start_reg);
                        seg_req.n     = TOT_W'(elem_idx_reg - run_start_reg);
                    end
                    else if (!new_run && (pos == WARP_BITS'(WARP_WIDTH - 1)))
                    begin
                        // warp ends inside the current run
                        seg_req.valid = 1'b1;
                        seg_req.diff  = diff_reg;
                        seg_req.base  = TOT_W'(run_start_reg);
                        seg_req.n     = TOT_W'(elem_idx_reg + CNT_W'(1) - run_start_reg);
                    end
                end
                else if (fin_go)
                begin
                    if (nb == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_KEY_RD:
            begin
                if (last_reg)
                begin
                    // one-key run at the end of the warp
                    seg_req.valid = 1'b1;
                    seg_req.diff  = diff_next;
                    seg_req.base  = TOT_W'(run_start_reg);
                    seg_req.n     = TOT_W'(elem_idx_reg - run_start_reg);
                end
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (rd_cnt_reg >= NB_W'(2))
                begin
                    // bucket before the one just read is complete
                    seg_req.valid  = 1'b1;
                    seg_req.to_opt = 1'b1;
                    seg_req.diff   = TOT_W'(prev_scatter_reg);
                    seg_req.base   = '0;
                    seg_req.n      = TOT_W'(gather_q) - TOT_W'(prev_gather_reg);
                end
                if (rd_cnt_reg < nb)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_cnt_reg[BKT_W-1:0];
                end
                else
                begin
                    state_next = ST_WALK_END;
                end
            end
            ST_WALK_END:
            begin
                // last bucket ends at the key count
                seg_req.valid  = 1'b1;
                seg_req.to_opt = 1'b1;
                seg_req.diff   = TOT_W'(prev_scatter_reg);
                seg_req.base   = '0;
                seg_req.n      = TOT_W'(nv) - TOT_W'(prev_gather_reg);
                state_next     = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!seg_busy && rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    stc_seg u_seg (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (seg_req),
        .rsp   (seg_rsp),
        .busy  (seg_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            elem_idx_reg     <= '0;
            run_start_reg    <= '0;
            run_key_reg      <= '0;
            last_reg         <= 1'b0;
            rd_cnt_reg       <= '0;
            simple_total_reg <= '0;
            opt_total_reg    <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (key_go)
            begin
                elem_idx_reg <= elem_idx_reg + CNT_W'(1);
                last_reg     <= (pos == WARP_BITS'(WARP_WIDTH - 1));
                if (new_run)
                begin
                    run_start_reg <= elem_idx_reg;
                    run_key_reg   <= req_data.key;
                end
            end

            if (fin_go)
            begin
                rd_cnt_reg <= NB_W'(1);
            end
            else if ((state_reg == ST_WALK) && (rd_cnt_reg < nb))
            begin
                rd_cnt_reg <= rd_cnt_reg + NB_W'(1);
            end

            if (seg_rsp.valid)
            begin
                if (seg_rsp.to_opt)
                begin
                    opt_total_reg <= opt_total_reg + seg_rsp.count;
                end
                else
                begin
                    simple_total_reg <= simple_total_reg + seg_rsp.count;
                end
            end

            if (rsp_load)
            begin
                elem_idx_reg     <= '0;
                run_start_reg    <= '0;
                run_key_reg      <= '0;
                rd_cnt_reg       <= '0;
                simple_total_reg <= '0;
                opt_total_reg    <= '0;
                rsp_valid_reg    <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KEY_RD)
        begin
            diff_reg <= diff_next;
        end
        else if (load_we && (req_data.bucket == run_key_reg))
        begin
            // a reload of the open run's bucket moves its destination
            diff_reg <= TOT_W'(req_data.scatter_offset) - TOT_W'(req_data.gather_offset);
        end
        if (state_reg == ST_WALK)
        begin
            prev_gather_reg  <= gather_q;
            prev_scatter_reg <= scatter_q;
        end
        if (rsp_load)
        begin
            rsp_data_reg.opt_transactions    <= opt_total_reg;
            rsp_data_reg.simple_transactions <= simple_total_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ---- assertions ----
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        elem_idx_reg <= CNT_W'(MAX_VALUES))
        else $error("element index beyond key limit");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        run_start_reg <= elem_idx_reg)
        else $error("run start ahead of element index");

    a_walk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> ((rd_cnt_reg != '0) && (rd_cnt_reg <= nb)))
        else $error("walk read count out of range");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> ((simple_total_reg == '0) && (opt_total_reg == '0)))
        else $error("totals not cleared after result");

    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DRAIN))
        else $error("result raised outside drain");

endmodule
